>>> hdl/rprk_pkg.sv
// Shared types and codes for the packet reorder block.
// No dependencies; imported by the top level, rprk_front and rprk_back.
`timescale 1ns / 1ps
package rprk_pkg;

    localparam logic [1:0] CMD_ARRIVE = 2'd0;
    localparam logic [1:0] CMD_TAKE   = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    localparam logic [1:0] KIND_ARRIVAL = 2'd0;
    localparam logic [1:0] KIND_DELIVER = 2'd1;
    localparam logic [1:0] KIND_ACK     = 2'd2;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DUP   = 3'd1;
    localparam logic [2:0] ST_STALE = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_NONE  = 3'd4;

    typedef enum logic [1:0] {
        OP_ARRIVE,
        OP_TAKE,
        OP_FLUSH
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        unrel;
        logic [31:0] seq;
        logic [15:0] handle;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] tag;
    } t_entry;

endpackage

>>> hdl/reliable_packet_reorder_with_acks.sv
// Top level of the receive reorder buffer with ack list.
// Depends on rprk_pkg, rprk_front, rprk_back and rprk_ram.
//
//  channel   handshake          beat
//  command   start / busy       i_cmd, i_seq_id, i_handle
//  result    o_strobe (1 cycle) o_kind, o_status, o_out_seq, o_out_handle, o_last
//
// Commands are queued two deep and carried out one at a time by a sequencer.
// A take reads the head of the store; a reliable arrival that is not stale walks the store,
// shifts the tail and walks the ack list; a flush emits one ack per cycle.
// Reset is synchronous and leaves the store and ack list empty with no clearing pass.
// Results cannot be stalled; busy is high only while the command queue is full.
`timescale 1ns / 1ps
module reliable_packet_reorder_with_acks #(
    parameter int STORE_DEPTH = 32,
    parameter int ACK_DEPTH   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_seq_id,
    input  logic [15:0] i_handle,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_status,
    output logic [31:0] o_out_seq,
    output logic [15:0] o_out_handle,
    output logic        o_last
);
    import rprk_pkg::*;

    t_qhead q_head;
    logic   q_pop;

    rprk_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .i_seq_id (i_seq_id),
        .i_handle (i_handle),
        .o_head   (q_head),
        .i_pop    (q_pop)
    );

    rprk_back #(.STORE_DEPTH(STORE_DEPTH), .ACK_DEPTH(ACK_DEPTH)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_strobe     (o_strobe),
        .o_kind       (o_kind),
        .o_status     (o_status),
        .o_out_seq    (o_out_seq),
        .o_out_handle (o_out_handle),
        .o_last       (o_last)
    );

    a_no_result_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_strobe)
        else $error("result beat right after reset");

    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_kind != KIND_ACK) |-> o_last)
        else $error("arrival or delivery beat without last");

    a_none_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status == ST_NONE) |-> (o_out_seq == 32'd0) && (o_out_handle == 16'd0))
        else $error("nothing-ready answer carries a packet");

    a_ack_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_kind == KIND_ACK) |-> (o_status == ST_OK) && (o_out_handle == 16'd0))
        else $error("ack beat with status or handle");
endmodule

>>> hdl/rprk_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module rprk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/rprk_front.sv
// Front end: takes command beats, classifies them and queues them for the back end.
// Depends on rprk_pkg.
`timescale 1ns / 1ps
module rprk_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_cmd,
    input  logic [31:0]          i_seq_id,
    input  logic [15:0]          i_handle,
    output rprk_pkg::t_qhead     o_head,
    input  logic                 i_pop
);
    import rprk_pkg::*;

    t_item      r_q [2];
    logic [1:0] r_cnt;
    logic       r_rp;
    logic       r_wp;
    logic       push;
    t_item      n_item;

    assign busy = (r_cnt == 2'd2);
    assign push = start && !busy && (i_cmd != 2'd3);

    always_comb begin
        n_item.unrel  = (i_seq_id == 32'd0);
        n_item.seq    = i_seq_id;
        n_item.handle = i_handle;
        case (i_cmd)
            CMD_TAKE:  n_item.op = OP_TAKE;
            CMD_FLUSH: n_item.op = OP_FLUSH;
            default:   n_item.op = OP_ARRIVE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rp  <= 1'b0;
            r_wp  <= 1'b0;
        end else begin
            if (push) begin
                r_q[r_wp] <= n_item;
                r_wp      <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rp];
endmodule

>>> hdl/rprk_back.sv
// Back end: sequencer over the ordered packet store and the ack list.
// Depends on rprk_pkg and rprk_ram.
`timescale 1ns / 1ps
module rprk_back #(
    parameter int STORE_DEPTH = 32,
    parameter int ACK_DEPTH   = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rprk_pkg::t_qhead i_head,
    output logic             o_pop,
    output logic             o_strobe,
    output logic [1:0]       o_kind,
    output logic [2:0]       o_status,
    output logic [31:0]      o_out_seq,
    output logic [15:0]      o_out_handle,
    output logic             o_last
);
    import rprk_pkg::*;

    localparam int SW  = $clog2(STORE_DEPTH);
    localparam int CW  = $clog2(STORE_DEPTH + 1);
    localparam int AW  = (ACK_DEPTH > 1) ? $clog2(ACK_DEPTH) : 1;
    localparam int ACW = $clog2(ACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_PLACE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_ACK_RD,
        S_ACK_CHK,
        S_HEAD_WAIT,
        S_FLUSH_OUT
    } t_state;

    function automatic logic [SW-1:0] phys(input logic [SW-1:0] h, input logic [CW-1:0] l);
        logic [CW:0] s;
        s = (CW + 1)'(h) + (CW + 1)'(l);
        if (s >= (CW + 1)'(STORE_DEPTH)) begin
            s = s - (CW + 1)'(STORE_DEPTH);
        end
        return s[SW-1:0];
    endfunction

    t_state      r_state;
    t_item       r_item;
    logic [SW-1:0]  r_head;
    logic [CW-1:0]  r_count;
    logic [31:0]    r_exp;
    logic [ACW-1:0] r_acnt;
    logic [CW-1:0]  r_idx;
    logic [CW-1:0]  r_pos;
    logic [ACW-1:0] r_aidx;
    logic [2:0]     r_status;
    logic           r_strobe;
    logic [1:0]     r_kind;
    logic [2:0]     r_st_o;
    logic [31:0]    r_seq_o;
    logic [15:0]    r_hdl_o;
    logic           r_last_o;

    logic          s_we;
    logic [SW-1:0] s_waddr;
    logic [SW-1:0] s_raddr;
    t_entry        s_wdata;
    t_entry        s_rdata;
    logic          a_we;
    logic [AW-1:0] a_waddr;
    logic [AW-1:0] a_raddr;
    logic [31:0]   a_rdata;
    logic [SW-1:0] head_m1;
    logic [SW-1:0] head_p1;
    logic          full;
    logic          stale;

    assign head_m1 = (r_head == '0) ? SW'(STORE_DEPTH - 1) : r_head - 1'b1;
    assign head_p1 = (r_head == SW'(STORE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign full    = (r_count >= CW'(STORE_DEPTH));
    assign stale   = !i_head.item.unrel && (i_head.item.seq < r_exp);
    assign o_pop   = (r_state == S_IDLE) && i_head.valid;

    always_comb begin
        s_we    = 1'b0;
        s_waddr = phys(r_head, r_idx);
        s_wdata = s_rdata;
        s_raddr = r_head;
        case (r_state)
            S_IDLE: begin
                s_we    = o_pop && (i_head.item.op == OP_ARRIVE) && i_head.item.unrel && !full;
                s_waddr = head_m1;
                s_wdata = {32'd0, i_head.item.handle};
            end
            S_SCAN_RD: begin
                s_raddr = phys(r_head, r_idx);
            end
            S_SHIFT_RD: begin
                s_raddr = phys(r_head, r_idx - 1'b1);
                s_we    = (r_idx == r_pos);
                s_waddr = phys(r_head, r_pos);
                s_wdata = {r_item.seq, r_item.handle};
            end
            S_SHIFT_WR: begin
                s_we = 1'b1;
            end
            default: begin
                s_raddr = r_head;
            end
        endcase
    end

    always_comb begin
        a_raddr = '0;
        case (r_state)
            S_ACK_RD:    a_raddr = r_aidx[AW-1:0];
            S_FLUSH_OUT: a_raddr = r_aidx[AW-1:0] + AW'(1);
            default:     a_raddr = '0;
        endcase
        a_we    = (r_state == S_ACK_RD) && (r_aidx == r_acnt) && (r_acnt < ACW'(ACK_DEPTH));
        a_waddr = r_acnt[AW-1:0];
    end

    rprk_ram #(.WIDTH(48), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    rprk_ram #(.WIDTH(32), .DEPTH(ACK_DEPTH)) u_acks (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (r_item.seq),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_exp    <= 32'd1;
            r_acnt   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_item <= i_head.item;
                        r_idx  <= '0;
                        r_aidx <= '0;
                        case (i_head.item.op)
                            OP_ARRIVE: begin
                                if (stale) begin
                                    r_status <= ST_STALE;
                                    r_state  <= S_ACK_RD;
                                end else if (i_head.item.unrel) begin
                                    r_strobe <= 1'b1;
                                    r_kind   <= KIND_ARRIVAL;
                                    r_seq_o  <= i_head.item.seq;
                                    r_hdl_o  <= 16'd0;
                                    r_last_o <= 1'b1;
                                    if (full) begin
                                        r_st_o <= ST_FULL;
                                    end else begin
                                        r_st_o  <= ST_OK;
                                        r_head  <= head_m1;
                                        r_count <= r_count + 1'b1;
                                    end
                                end else begin
                                    r_state <= S_SCAN_RD;
                                end
                            end
                            OP_TAKE: begin
                                if (r_count == '0) begin
                                    r_strobe <= 1'b1;
                                    r_kind   <= KIND_DELIVER;
                                    r_st_o   <= ST_NONE;
                                    r_seq_o  <= 32'd0;
                                    r_hdl_o  <= 16'd0;
                                    r_last_o <= 1'b1;
                                end else begin
                                    r_state <= S_HEAD_WAIT;
                                end
                            end
                            default: begin
                                if (r_acnt != '0) begin
                                    r_state <= S_FLUSH_OUT;
                                end
                            end
                        endcase
                    end
                end
                S_SCAN_RD: begin
                    if (r_idx == r_count) begin
                        r_pos   <= r_count;
                        r_state <= S_PLACE;
                    end else begin
                        r_state <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK: begin
                    if (s_rdata.id == r_item.seq) begin
                        r_status <= ST_DUP;
                        r_state  <= S_ACK_RD;
                    end else if (s_rdata.id > r_item.seq) begin
                        r_pos   <= r_idx;
                        r_state <= S_PLACE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_PLACE: begin
                    if (full) begin
                        r_strobe <= 1'b1;
                        r_kind   <= KIND_ARRIVAL;
                        r_st_o   <= ST_FULL;
                        r_seq_o  <= r_item.seq;
                        r_hdl_o  <= 16'd0;
                        r_last_o <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_idx   <= r_count;
                        r_state <= S_SHIFT_RD;
                    end
                end
                S_SHIFT_RD: begin
                    if (r_idx == r_pos) begin
                        r_count  <= r_count + 1'b1;
                        r_status <= ST_OK;
                        r_state  <= S_ACK_RD;
                    end else begin
                        r_state <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR: begin
                    r_idx   <= r_idx - 1'b1;
                    r_state <= S_SHIFT_RD;
                end
                S_ACK_RD: begin
                    if (r_aidx == r_acnt) begin
                        if (a_we) begin
                            r_acnt <= r_acnt + 1'b1;
                        end
                        r_strobe <= 1'b1;
                        r_kind   <= KIND_ARRIVAL;
                        r_st_o   <= r_status;
                        r_seq_o  <= r_item.seq;
                        r_hdl_o  <= 16'd0;
                        r_last_o <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_ACK_CHK;
                    end
                end
                S_ACK_CHK: begin
                    if (a_rdata == r_item.seq) begin
                        r_strobe <= 1'b1;
                        r_kind   <= KIND_ARRIVAL;
                        r_st_o   <= r_status;
                        r_seq_o  <= r_item.seq;
                        r_hdl_o  <= 16'd0;
                        r_last_o <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_aidx  <= r_aidx + 1'b1;
                        r_state <= S_ACK_RD;
                    end
                end
                S_HEAD_WAIT: begin
                    r_strobe <= 1'b1;
                    r_kind   <= KIND_DELIVER;
                    r_last_o <= 1'b1;
                    if ((s_rdata.id == 32'd0) || (s_rdata.id == r_exp)) begin
                        r_st_o  <= ST_OK;
                        r_seq_o <= s_rdata.id;
                        r_hdl_o <= s_rdata.tag;
                        r_head  <= head_p1;
                        r_count <= r_count - 1'b1;
                        if (s_rdata.id != 32'd0) begin
                            r_exp <= r_exp + 32'd1;
                        end
                    end else begin
                        r_st_o  <= ST_NONE;
                        r_seq_o <= 32'd0;
                        r_hdl_o <= 16'd0;
                    end
                    r_state <= S_IDLE;
                end
                S_FLUSH_OUT: begin
                    r_strobe <= 1'b1;
                    r_kind   <= KIND_ACK;
                    r_st_o   <= ST_OK;
                    r_seq_o  <= a_rdata;
                    r_hdl_o  <= 16'd0;
                    r_aidx   <= r_aidx + 1'b1;
                    if (r_aidx + 1'b1 == r_acnt) begin
                        r_last_o <= 1'b1;
                        r_acnt   <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_last_o <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe     = r_strobe;
    assign o_kind       = r_kind;
    assign o_status     = r_st_o;
    assign o_out_seq    = r_seq_o;
    assign o_out_handle = r_hdl_o;
    assign o_last       = r_last_o;
endmodule
